### hdl/pge_pkg.sv
// Shared types and constants of the pixel gradient energy map.
// Holds the request, response and queue record formats; no dependencies.
package pge_pkg;

   // Field widths fixed by the external interface
   localparam int PIX_W        = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int OUT_ROW_W    = 12;
   localparam int OUT_COL_W    = 10;
   localparam int ENERGY_W     = 10;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Result slots carried by one record, in emission order
   localparam int RES_N    = 3;
   localparam int RES_UP   = 0;   // pixel above, finished by its down neighbor
   localparam int RES_LEFT = 1;   // left pixel on the last row
   localparam int RES_MINE = 2;   // the pixel itself, last column of the last row

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic [ENERGY_W-1:0]  energy;
      logic                 last_of_run;
   } rsp_type;

   // One classified request with its finished energies
   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [RES_N-1:0]     mask;
      logic [ENERGY_W-1:0]  e_up;
      logic [ENERGY_W-1:0]  e_left;
      logic [ENERGY_W-1:0]  e_mine;
   } rec_type;

endpackage

### hdl/pixel_gradient_energy_map.sv
// Gradient energy map of a raster-order RGB stream.
// Top level: configuration registers, front end, queue and back end.
//
// Usage:
//   req_*  : one RGB pixel per request, raster order, valid/ready.
//   rsp_*  : energies with row and column, valid/ready; last_of_run marks the
//            final result caused by one pixel.
//   csr_*  : write port for frame_width (index 0) and frame_height (index 1);
//            any write to either restarts the frame at row 0, column 0.
// A pixel's energy is sent when its down neighbor arrives; on the last row
// it is sent when its right neighbor arrives, and the final pixel last.
// Path: a request passes the compute stage register, the queue and the
// response register, which presents the result that the request completes.
// Throughput: one pixel per cycle and one result per cycle while rsp_ready
// is held high. The response register sends one result a cycle, so on the
// last row, where a pixel yields two or three results, the input slows to match.
// A stalled receiver fills the response register, the 4-entry queue and the
// compute stage, after which req_ready drops. Reset clears counters, queue
// and output and loads the reset frame size; the line stores need no clearing.
module pixel_gradient_energy_map #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pge_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pge_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wen,
   input  logic [pge_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pge_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pge_pkg::*;

   localparam int WCNT_W       = $clog2(MAX_WIDTH+1);
   localparam int HCNT_W       = $clog2(MAX_HEIGHT+1);
   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 768;

   // Zero acts as one, oversize acts as the maximum
   function automatic int clamp_dim(input int v, input int maxv);
      if (v == 0) begin
         return 1;
      end
      return (v > maxv) ? maxv : v;
   endfunction

   logic [WCNT_W-1:0] frame_w_ff, frame_w_in;
   logic [HCNT_W-1:0] frame_h_ff, frame_h_in;
   logic              restart;
   logic              rec_valid, rec_ready, q_valid, q_ready;
   rec_type           rec_data, q_data;

   // Configuration registers, held already clamped
   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      restart    = 1'b0;
      if (csr_wen) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_w_in = WCNT_W'(clamp_dim(int'(csr_wdata[CFG_WIDTH_W-1:0]), MAX_WIDTH));
               restart    = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               frame_h_in = HCNT_W'(clamp_dim(int'(csr_wdata[CFG_HEIGHT_W-1:0]),
                                              MAX_HEIGHT));
               restart    = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= WCNT_W'(clamp_dim(RESET_WIDTH, MAX_WIDTH));
         frame_h_ff <= HCNT_W'(clamp_dim(RESET_HEIGHT, MAX_HEIGHT));
      end else begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   pge_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .frame_w   (frame_w_ff),
      .frame_h   (frame_h_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec_data  (rec_data)
   );

   pge_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rec_valid),
      .in_ready  (rec_ready),
      .in_data   (rec_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   pge_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_ready (q_ready),
      .head_data  (q_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // A record blocked at the queue must hold off new requests
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      rec_valid && !rec_ready |-> !req_ready)
      else $error("request accepted while compute stage is blocked");

   // A waiting record with an empty response register is loaded next cycle
   a_back_load: assert property (@(posedge clock) disable iff (reset)
      q_valid && !rsp_valid |=> rsp_valid)
      else $error("queued record not moved to response register");

   // No response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

### hdl/pge_front.sv
// Front end: accepts pixels, tracks the raster position, keeps the line stores
// and computes the neighbor terms of each request. Depends on pge_pkg.
module pge_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   frame_h,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pge_pkg::req_type                  req_data,
   output logic                              rec_valid,
   input  logic                              rec_ready,
   output pge_pkg::rec_type                  rec_data
);
   import pge_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WCNT_W     = $clog2(MAX_WIDTH+1);
   localparam int HCNT_W     = $clog2(MAX_HEIGHT+1);
   localparam int SUM_W      = 10;
   localparam int PROD_W     = 20;
   localparam int DIV3_MUL   = 683;   // floor(s/3) == (s*683)>>11 for s <= 765
   localparam int DIV3_SHIFT = 11;

   function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // (|dR|+|dG|+|dB|)/3 by reciprocal multiply
   function automatic logic [PIX_W-1:0] pair_term(input req_type p, input req_type q);
      logic [SUM_W-1:0]  s;
      logic [PROD_W-1:0] prod;
      s = SUM_W'(absdiff(p.red, q.red)) + SUM_W'(absdiff(p.green, q.green))
          + SUM_W'(absdiff(p.blue, q.blue));
      prod = PROD_W'(s) * PROD_W'(DIV3_MUL);
      return prod[DIV3_SHIFT +: PIX_W];
   endfunction

   // Position of the next pixel
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                acc, last_col0, last_row0;

   // Line stores
   req_type             pix_mem [MAX_WIDTH];
   logic [ENERGY_W-1:0] part_mem [MAX_WIDTH];
   req_type             up_pix_ff;
   logic [ENERGY_W-1:0] up_part_ff;
   logic                fwd_hit_ff;
   logic [ENERGY_W-1:0] fwd_val_ff;

   // Compute stage
   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_pix_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_has_up_ff, s1_last_row_ff, s1_last_col_ff;
   req_type             left_ff;
   logic [ENERGY_W-1:0] pending_ff, tail_ff;

   logic                has_left, s1_fire, wr_en;
   logic [COL_W-1:0]    wr_addr;
   logic [PIX_W-1:0]    vt, ht;
   logic [ENERGY_W-1:0] up_part, e_up, e_left, e_mine;
   logic [RES_N-1:0]    mask;

   assign acc       = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign last_col0 = (WCNT_W'(col_ff) + WCNT_W'(1)) == frame_w;
   assign last_row0 = (HCNT_W'(row_ff) + HCNT_W'(1)) == frame_h;

   // Raster counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (acc) begin
         if (last_col0) begin
            col_in = '0;
            row_in = last_row0 ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line stores: read old contents at the accepted column, forward a partial
   // written by the compute stage in the same cycle
   always_ff @(posedge clock) begin
      if (acc) begin
         pix_mem[col_ff] <= req_data;
         up_pix_ff       <= pix_mem[col_ff];
         up_part_ff      <= part_mem[col_ff];
         fwd_hit_ff      <= wr_en && (wr_addr == col_ff);
         fwd_val_ff      <= e_left;
      end
      if (wr_en) begin
         part_mem[wr_addr] <= e_left;
      end
   end

   // Compute stage register
   assign s1_valid_in = acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff      <= req_data;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_has_up_ff   <= (row_ff != '0);
         s1_last_row_ff <= last_row0;
         s1_last_col_ff <= last_col0;
      end
   end

   // Neighbor terms and finished energies
   always_comb begin
      has_left = (s1_col_ff != '0);
      vt       = pair_term(s1_pix_ff, up_pix_ff);
      ht       = pair_term(s1_pix_ff, left_ff);
      if (s1_last_col_ff) begin
         up_part = tail_ff;
      end else if (fwd_hit_ff) begin
         up_part = fwd_val_ff;
      end else begin
         up_part = up_part_ff;
      end
      e_up   = up_part + ENERGY_W'(vt);
      e_left = pending_ff + ENERGY_W'(ht);
      e_mine = (s1_has_up_ff ? ENERGY_W'(vt) : '0) + (has_left ? ENERGY_W'(ht) : '0);
      mask           = '0;
      mask[RES_UP]   = s1_has_up_ff;
      mask[RES_LEFT] = has_left && s1_last_row_ff;
      mask[RES_MINE] = s1_last_col_ff && s1_last_row_ff;
      s1_fire  = s1_valid_ff && ((mask == '0) || rec_ready);
      wr_en    = s1_fire && has_left && !s1_last_row_ff;
      wr_addr  = s1_col_ff - COL_W'(1);
   end

   // Row state carried from pixel to pixel
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         left_ff    <= s1_pix_ff;
         pending_ff <= s1_last_col_ff ? '0 : e_mine;
         if (s1_last_col_ff && !s1_last_row_ff) begin
            tail_ff <= e_mine;
         end
      end
   end

   // Record toward the back end; requests with no result are dropped here
   assign rec_valid       = s1_valid_ff && (mask != '0);
   assign rec_data.row    = OUT_ROW_W'(s1_row_ff);
   assign rec_data.col    = OUT_COL_W'(s1_col_ff);
   assign rec_data.mask   = mask;
   assign rec_data.e_up   = e_up;
   assign rec_data.e_left = e_left;
   assign rec_data.e_mine = e_mine;

endmodule

### hdl/pge_queue.sv
// Short record queue between front and back ends.
// Register array with read and write pointers; depends on pge_pkg.
module pge_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pge_pkg::rec_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pge_pkg::rec_type out_data
);
   import pge_pkg::*;

   rec_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hdl/pge_back.sv
// Back end: expands each queued record into its results, one per cycle while
// rsp_ready is high, through the response register. Depends on pge_pkg.
module pge_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   output logic             head_ready,
   input  pge_pkg::rec_type head_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pge_pkg::rsp_type rsp_data
);
   import pge_pkg::*;

   logic [RES_N-1:0] done_ff, done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [RES_N-1:0] remain, sel;
   logic             load, last;

   // Pick the earliest result of the head record not yet sent
   always_comb begin
      remain = head_data.mask & ~done_ff;
      sel    = remain & (~remain + RES_N'(1));
      last   = (remain & ~sel) == '0;
      load   = head_valid && (!rsp_valid_ff || rsp_ready);
      rsp_in = rsp_ff;
      if (sel[RES_UP]) begin
         rsp_in.out_row = head_data.row - OUT_ROW_W'(1);
         rsp_in.out_col = head_data.col;
         rsp_in.energy  = head_data.e_up;
      end else if (sel[RES_LEFT]) begin
         rsp_in.out_row = head_data.row;
         rsp_in.out_col = head_data.col - OUT_COL_W'(1);
         rsp_in.energy  = head_data.e_left;
      end else begin
         rsp_in.out_row = head_data.row;
         rsp_in.out_col = head_data.col;
         rsp_in.energy  = head_data.e_mine;
      end
      rsp_in.last_of_run = last;
      done_in = done_ff;
      if (load) begin
         done_in = last ? '0 : (done_ff | sel);
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign head_ready = load && last;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
